FILE: design/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold whenever the antecedent holds
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/bpps_pkg.sv
// shared types, constants and pattern tables of the buzzer sequencer
`default_nettype none

package bpps_pkg;

	localparam int unsigned QUEUE_DEPTH = 8;
	localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_PLAY   = 2'd1,
		CMD_CUSTOM = 2'd2,
		CMD_MUTE   = 2'd3
	} cmd_t;

	localparam logic [2:0] PAT_CLICK    = 3'd0;
	localparam logic [2:0] PAT_SUCCESS  = 3'd1;
	localparam logic [2:0] PAT_WARNING  = 3'd2;
	localparam logic [2:0] PAT_CRITICAL = 3'd3;
	localparam logic [2:0] PAT_CUSTOM   = 3'd4;

	typedef struct packed {
		logic [2:0]  pattern;
		logic [15:0] length;
	} item_t;

	// queue control broadcast to every cell
	typedef struct packed {
		logic       ins;
		logic       deq;
		logic [1:0] prio;
		item_t      item;
	} qctrl_t;

	// sequencer status toward the top level
	typedef struct packed {
		logic muted;
		logic busy;
		logic drive;
		logic deq;
	} seq_stat_t;

	function automatic logic [1:0] prio_of(input logic [2:0] p);
		logic [1:0] r;
		r = 2'd0;
		unique case (p)
			PAT_CRITICAL: r = 2'd3;
			PAT_WARNING:  r = 2'd2;
			PAT_SUCCESS:  r = 2'd1;
			default:      r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] seg_count(input logic [2:0] p);
		logic [2:0] r;
		r = 3'd1;
		unique case (p)
			PAT_SUCCESS:  r = 3'd3;
			PAT_WARNING:  r = 3'd3;
			PAT_CRITICAL: r = 3'd5;
			default:      r = 3'd1;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] seg_len(input logic [2:0] p, input logic [2:0] idx,
		input logic [15:0] custom);
		logic [15:0] r;
		r = 16'd0;
		if (p[2]) begin
			r = custom;
		end else begin
			unique case (p[1:0])
				PAT_CLICK[1:0]:    r = (idx == 3'd0) ? 16'd60 : 16'd0;
				PAT_SUCCESS[1:0]:  r = (idx < 3'd3) ? 16'd80 : 16'd0;
				PAT_WARNING[1:0]:  r = (idx < 3'd3) ? 16'd90 : 16'd0;
				default: begin
					if (idx >= 3'd5)
						r = 16'd0;
					else
						r = idx[0] ? 16'd80 : 16'd140;
				end
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/bpps_cell.sv
// one slot of the sorted request queue, shifts toward either neighbor
`default_nettype none

module bpps_cell (
	input  wire logic            clk,
	input  wire bpps_pkg::qctrl_t ctrl,
	input  wire logic            vld,
	input  wire logic            left_vld,
	input  wire logic            left_gt,
	input  wire bpps_pkg::item_t left_item,
	input  wire bpps_pkg::item_t right_item,
	output bpps_pkg::item_t      item_q,
	output logic                 gt
);
	import bpps_pkg::*;

	// slot holds a lower priority than the incoming request
	assign gt = vld && (prio_of(item_q.pattern) < ctrl.prio);

	always_ff @(posedge clk) begin
		if (ctrl.deq) begin
			item_q <= right_item;
		end else if (ctrl.ins && (gt || !vld)) begin
			if (left_gt)
				item_q <= left_item;
			else if (left_vld)
				item_q <= ctrl.item;
		end
	end

endmodule

`default_nettype wire

FILE: design/bpps_seq.sv
// segment sequencer: mute flag, active pattern and millisecond timing
`default_nettype none

module bpps_seq (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             fire,
	input  wire logic [1:0]       cmd,
	input  wire logic             mute,
	input  wire logic             q_nonempty,
	input  wire bpps_pkg::item_t  head,
	output bpps_pkg::seq_stat_t   stat
);
	import bpps_pkg::*;

	logic        muted_q;
	logic        busy_q;
	logic        drive_q;
	logic [2:0]  pat_q;
	logic [15:0] len_q;
	logic [2:0]  idx_q;
	logic [15:0] rem_q;

	logic        tick;
	logic [15:0] rem_dec;
	logic [2:0]  idx_nxt;

	assign tick    = fire && (cmd == CMD_TICK);
	assign rem_dec = (rem_q != 16'd0) ? rem_q - 16'd1 : 16'd0;
	assign idx_nxt = idx_q + 3'd1;

	assign stat.muted = muted_q;
	assign stat.busy  = busy_q;
	assign stat.drive = drive_q;
	assign stat.deq   = tick && !busy_q && q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			muted_q <= 1'b0;
			busy_q  <= 1'b0;
			drive_q <= 1'b0;
			pat_q   <= 3'd0;
			len_q   <= 16'd0;
			idx_q   <= 3'd0;
			rem_q   <= 16'd0;
		end else if (fire) begin
			if (cmd == CMD_MUTE) begin
				muted_q <= mute;
				if (mute)
					drive_q <= 1'b0;
			end else if (cmd == CMD_TICK) begin
				if (busy_q) begin
					rem_q <= rem_dec;
					if (rem_dec == 16'd0) begin
						if (idx_nxt >= seg_count(pat_q)) begin
							busy_q  <= 1'b0;
							drive_q <= 1'b0;
						end else begin
							idx_q   <= idx_nxt;
							rem_q   <= seg_len(pat_q, idx_nxt, len_q);
							drive_q <= !idx_nxt[0] && !muted_q;
						end
					end
				end else if (q_nonempty) begin
					pat_q <= head.pattern;
					len_q <= head.length;
					// muted heads and empty custom beeps are dropped here
					if (!muted_q && !(head.pattern[2] && head.length == 16'd0)) begin
						busy_q  <= 1'b1;
						idx_q   <= 3'd0;
						rem_q   <= seg_len(head.pattern, 3'd0, head.length);
						drive_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/buzzer_pattern_priority_sequencer_core.sv
// top level of the buzzer pattern priority sequencer
`default_nettype none
`include "assert_macros.svh"

// Buzzer pattern priority sequencer. Each request carries a command: a
// one-millisecond tick, a play-pattern request, a custom beep request or
// a mute setting. Pattern and custom requests are held in a sorted queue
// built as a chain of identical slots; a new request is inserted behind
// every request of equal or higher priority (critical 3, warning 2,
// success 1, click and custom 0), and the slots behind it shift one place
// in the same cycle. A tick on an idle sequencer removes the head and all
// slots shift toward the head. Requests are dropped while muted or when
// all slots are full. Each request is taken into the result register,
// one result per request, which appears there in the next cycle
// and reflects the state after that request. The block takes
// the next request as soon as the result has been taken (or in the same
// cycle it is taken), so the sustained rate is one request per cycle when
// the result side never stalls. The result register is the block state
// itself, so the request side stalls while a result is held.
module buzzer_pattern_priority_sequencer_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic [2:0]  pattern,
	input  wire logic [15:0] duration_ms,
	input  wire logic        mute,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             buzzer_on,
	output logic             muted_now,
	output logic [3:0]       queued_count,
	output logic             accepted,
	output logic             playing
);
	import bpps_pkg::*;

	logic             res_valid_q;
	logic             acc_q;
	logic [CNT_W-1:0] cnt_q;

	logic             req_fire;
	logic             is_req;
	logic             ins;
	item_t            new_item;
	qctrl_t           q_ctrl;
	seq_stat_t        stat;

	item_t            cell_item [QUEUE_DEPTH];
	logic             cell_gt   [QUEUE_DEPTH];
	logic             cell_vld  [QUEUE_DEPTH];

	// one result register stands between the two sides
	assign req_stall = res_valid_q && res_stall;
	assign req_fire  = req_valid && !req_stall;

	// request decode: custom beeps enter as pattern custom with their length
	assign is_req   = (cmd == CMD_PLAY) || (cmd == CMD_CUSTOM);
	assign new_item.pattern = (cmd == CMD_CUSTOM) ? PAT_CUSTOM : pattern;
	assign new_item.length  = (cmd == CMD_CUSTOM) ? duration_ms : 16'd0;
	assign ins = req_fire && is_req && !stat.muted && (cnt_q < CNT_W'(QUEUE_DEPTH));

	assign q_ctrl.ins  = ins;
	assign q_ctrl.deq  = stat.deq;
	assign q_ctrl.prio = prio_of(new_item.pattern);
	assign q_ctrl.item = new_item;

	// slot chain, head at index 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		assign cell_vld[i] = cnt_q > CNT_W'(i);
		if (i == 0) begin : g_head
			bpps_cell u_cell (
				.clk        (clk),
				.ctrl       (q_ctrl),
				.vld        (cell_vld[i]),
				.left_vld   (1'b1),
				.left_gt    (1'b0),
				.left_item  (new_item),
				.right_item ((QUEUE_DEPTH > 1) ? cell_item[(i + 1) % QUEUE_DEPTH] : cell_item[i]),
				.item_q     (cell_item[i]),
				.gt         (cell_gt[i])
			);
		end else begin : g_body
			bpps_cell u_cell (
				.clk        (clk),
				.ctrl       (q_ctrl),
				.vld        (cell_vld[i]),
				.left_vld   (cell_vld[i-1]),
				.left_gt    (cell_gt[i-1]),
				.left_item  (cell_item[i-1]),
				.right_item ((i == QUEUE_DEPTH - 1) ? cell_item[i] :
					cell_item[(i + 1) % QUEUE_DEPTH]),
				.item_q     (cell_item[i]),
				.gt         (cell_gt[i])
			);
		end
	end

	bpps_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (req_fire),
		.cmd        (cmd),
		.mute       (mute),
		.q_nonempty (cnt_q != '0),
		.head       (cell_item[0]),
		.stat       (stat)
	);

	// fill count and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			acc_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (ins)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (stat.deq)
				cnt_q <= cnt_q - CNT_W'(1);
			if (req_fire) begin
				acc_q       <= ins;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign buzzer_on    = stat.drive;
	assign muted_now    = stat.muted;
	assign queued_count = 4'(cnt_q);
	assign accepted     = acc_q;
	assign playing      = stat.busy;

	`ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
	`ASSERT_ALWAYS(a_ins_deq_excl, clk, arst_n, !(q_ctrl.ins && q_ctrl.deq), "insert and remove together")
	`ASSERT_IMPLIES(a_drive_busy, clk, arst_n, stat.drive, stat.busy, "buzzer driven while idle")
	`ASSERT_IMPLIES(a_cnt_hold, clk, arst_n, !$past(req_fire), $stable(cnt_q), "count moved without request")

endmodule

`default_nettype wire

FILE: dv/buzzer_pattern_priority_sequencer_core_test.sv
// testbench of the buzzer sequencer: directed request table, then random requests
`timescale 1ns / 1ps

module buzzer_pattern_priority_sequencer_core_test;
	import bpps_pkg::*;

	// pattern codes with no name in the package, all of them behave as custom
	localparam logic [2:0] PAT_SPARE_LO  = 3'd5;
	localparam logic [2:0] PAT_SPARE_MID = 3'd6;
	localparam logic [2:0] PAT_SPARE_HI  = 3'd7;

	localparam int          NUM_RANDOM  = 1750;
	localparam int unsigned CYCLE_LIMIT = 200_000;

	// one result as the block reports it, after the request took effect
	typedef struct packed {
		logic       buzz;
		logic       muted;
		logic [3:0] waiting;
		logic       taken;
		logic       busy;
	} buzzer_status_t;

	// one row of the directed table; typed rows carry their result inline
	typedef struct packed {
		cmd_t           op;
		logic [2:0]     pat;
		logic [15:0]    ms;
		logic           mu;
		logic           typed;
		buzzer_status_t want;
	} stim_row_t;

	localparam int SCRIPT_LEN = 25;
	localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
		// fresh out of reset: tick and unmute do nothing
		'{CMD_TICK,   PAT_CLICK,    16'd0,      1'b0, 1'b1, '{1'b0, 1'b0, 4'd0, 1'b0, 1'b0}},
		'{CMD_MUTE,   PAT_CLICK,    16'd0,      1'b0, 1'b1, '{1'b0, 1'b0, 4'd0, 1'b0, 1'b0}},
		// click is queued, then the idle tick dequeues it and sounds at once
		'{CMD_PLAY,   PAT_CLICK,    16'd0,      1'b0, 1'b1, '{1'b0, 1'b0, 4'd1, 1'b1, 1'b0}},
		'{CMD_TICK,   PAT_CLICK,    16'd0,      1'b0, 1'b1, '{1'b1, 1'b0, 4'd0, 1'b0, 1'b1}},
		// fill all eight slots while the click plays, mixed priorities
		'{CMD_CUSTOM, PAT_CLICK,    16'd0,      1'b0, 1'b1, '{1'b1, 1'b0, 4'd1, 1'b1, 1'b1}},
		'{CMD_PLAY,   PAT_SPARE_HI, 16'd0,      1'b0, 1'b1, '{1'b1, 1'b0, 4'd2, 1'b1, 1'b1}},
		'{CMD_PLAY,   PAT_CRITICAL, 16'd0,      1'b0, 1'b1, '{1'b1, 1'b0, 4'd3, 1'b1, 1'b1}},
		'{CMD_PLAY,   PAT_SUCCESS,  16'd0,      1'b0, 1'b1, '{1'b1, 1'b0, 4'd4, 1'b1, 1'b1}},
		'{CMD_PLAY,   PAT_WARNING,  16'd0,      1'b0, 1'b1, '{1'b1, 1'b0, 4'd5, 1'b1, 1'b1}},
		'{CMD_CUSTOM, PAT_CLICK,    16'd1,      1'b0, 1'b1, '{1'b1, 1'b0, 4'd6, 1'b1, 1'b1}},
		'{CMD_PLAY,   PAT_SPARE_LO, 16'd0,      1'b0, 1'b1, '{1'b1, 1'b0, 4'd7, 1'b1, 1'b1}},
		'{CMD_CUSTOM, PAT_CLICK,    16'd37,     1'b0, 1'b1, '{1'b1, 1'b0, 4'd8, 1'b1, 1'b1}},
		// queue full: both requests dropped
		'{CMD_CUSTOM, PAT_CLICK,    16'hFFFF,   1'b0, 1'b1, '{1'b1, 1'b0, 4'd8, 1'b0, 1'b1}},
		'{CMD_PLAY,   PAT_CRITICAL, 16'd0,      1'b0, 1'b1, '{1'b1, 1'b0, 4'd8, 1'b0, 1'b1}},
		// mute cuts the drive at once, requests are dropped while muted
		'{CMD_MUTE,   PAT_CLICK,    16'd0,      1'b1, 1'b1, '{1'b0, 1'b1, 4'd8, 1'b0, 1'b1}},
		'{CMD_PLAY,   PAT_SPARE_MID, 16'd0,     1'b0, 1'b1, '{1'b0, 1'b1, 4'd8, 1'b0, 1'b1}},
		'{CMD_CUSTOM, PAT_CLICK,    16'hAAAA,   1'b0, 1'b1, '{1'b0, 1'b1, 4'd8, 1'b0, 1'b1}},
		'{CMD_TICK,   PAT_CLICK,    16'd0,      1'b0, 1'b0, '0},
		// unmute mid segment: the drive stays off until the next on segment
		'{CMD_MUTE,   PAT_CLICK,    16'd0,      1'b0, 1'b1, '{1'b0, 1'b0, 4'd8, 1'b0, 1'b1}},
		'{CMD_TICK,   PAT_CLICK,    16'd0,      1'b0, 1'b0, '0},
		'{CMD_PLAY,   PAT_CUSTOM,   16'd0,      1'b0, 1'b1, '{1'b0, 1'b0, 4'd8, 1'b0, 1'b1}},
		'{CMD_CUSTOM, PAT_CLICK,    16'h5555,   1'b0, 1'b1, '{1'b0, 1'b0, 4'd8, 1'b0, 1'b1}},
		// unused fields at their extremes must not matter
		'{CMD_MUTE,   PAT_SPARE_HI, 16'hFFFF,   1'b1, 1'b1, '{1'b0, 1'b1, 4'd8, 1'b0, 1'b1}},
		'{CMD_MUTE,   PAT_SPARE_HI, 16'hFFFF,   1'b0, 1'b1, '{1'b0, 1'b0, 4'd8, 1'b0, 1'b1}},
		'{CMD_TICK,   PAT_SPARE_HI, 16'hFFFF,   1'b1, 1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	cmd_t        cmd;
	logic [2:0]  pattern;
	logic [15:0] duration_ms;
	logic        mute;
	logic        res_valid;
	logic        res_stall;
	logic        buzzer_on;
	logic        muted_now;
	logic [3:0]  queued_count;
	logic        accepted;
	logic        playing;

	buzzer_pattern_priority_sequencer_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.cmd          (cmd),
		.pattern      (pattern),
		.duration_ms  (duration_ms),
		.mute         (mute),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.buzzer_on    (buzzer_on),
		.muted_now    (muted_now),
		.queued_count (queued_count),
		.accepted     (accepted),
		.playing      (playing)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// predictor state: the sorted request queue and the tone sequencer
	item_t       slot [QUEUE_DEPTH];
	int          n_waiting;
	logic        muted_st;
	logic [2:0]  act_pat;
	logic [15:0] act_len;
	logic [2:0]  seg_idx;
	logic [15:0] seg_left;
	logic        busy_st;
	logic        drive_st;

	buzzer_status_t status_due [$];   // one per request taken, oldest first
	int             mismatches = 0;
	int unsigned    cycle_no = 0;
	bit             steady;           // stretch with no idling on either side

	function automatic int idle_cycles();
		return steady ? 0 : $urandom_range(0, 3);
	endfunction

	function automatic logic [1:0] urgency(input logic [2:0] pat);
		case (pat)
			PAT_CRITICAL: return 2'd3;
			PAT_WARNING:  return 2'd2;
			PAT_SUCCESS:  return 2'd1;
			default:      return 2'd0;
		endcase
	endfunction

	function automatic logic [2:0] tone_count(input logic [2:0] pat);
		case (pat)
			PAT_SUCCESS, PAT_WARNING: return 3'd3;
			PAT_CRITICAL:             return 3'd5;
			default:                  return 3'd1;
		endcase
	endfunction

	// even segments sound, odd ones are gaps; custom has one segment
	function automatic void open_segment(input logic [2:0] idx);
		seg_idx = idx;
		case (act_pat)
			PAT_CLICK:    seg_left = 16'd60;
			PAT_SUCCESS:  seg_left = 16'd80;
			PAT_WARNING:  seg_left = 16'd90;
			PAT_CRITICAL: seg_left = idx[0] ? 16'd80 : 16'd140;
			default:      seg_left = act_len;
		endcase
		drive_st = idx[0] ? 1'b0 : !muted_st;
	endfunction

	// insert behind every request of equal or higher urgency
	function automatic logic enqueue_request(input logic [2:0] pat, input logic [15:0] len);
		int         pos;
		logic [1:0] urg;
		urg = urgency(pat);
		if (muted_st || n_waiting >= QUEUE_DEPTH)
			return 1'b0;
		pos = n_waiting;
		while (pos > 0 && urgency(slot[pos - 1].pattern) < urg) begin
			slot[pos] = slot[pos - 1];
			pos--;
		end
		slot[pos] = '{pattern: pat, length: len};
		n_waiting++;
		return 1'b1;
	endfunction

	task automatic step_buzzer(input cmd_t op, input logic [2:0] pat, input logic [15:0] ms,
		input logic mu, output buzzer_status_t st);
		logic       taken;
		logic [2:0] nxt;
		taken = 1'b0;
		case (op)
			CMD_TICK: begin
				if (busy_st) begin
					if (seg_left != 16'd0)
						seg_left--;
					if (seg_left == 16'd0) begin
						nxt = seg_idx + 3'd1;
						if (nxt >= tone_count(act_pat)) begin
							busy_st  = 1'b0;
							drive_st = 1'b0;
						end else begin
							open_segment(nxt);
						end
					end
				end else if (n_waiting != 0) begin
					// idle tick: pop the head; muted or empty custom plays nothing
					act_pat = slot[0].pattern;
					act_len = slot[0].length;
					for (int i = 1; i < n_waiting; i++)
						slot[i - 1] = slot[i];
					n_waiting--;
					if (!muted_st && !(act_pat >= PAT_CUSTOM && act_len == 16'd0)) begin
						busy_st = 1'b1;
						open_segment(3'd0);
					end
				end
			end
			CMD_PLAY:   taken = enqueue_request(pat, 16'd0);
			CMD_CUSTOM: taken = enqueue_request(PAT_CUSTOM, ms);
			default: begin
				muted_st = mu;
				if (mu)
					drive_st = 1'b0;
			end
		endcase
		st = '{buzz: drive_st, muted: muted_st, waiting: n_waiting[3:0], taken: taken,
			busy: busy_st};
	endtask

	// drive one request, wait for its handshake, and log what it should produce
	task automatic put_request(input cmd_t op, input logic [2:0] pat, input logic [15:0] ms,
		input logic mu, input logic typed, input buzzer_status_t want);
		int             gap;
		buzzer_status_t pred;
		gap = idle_cycles();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd         <= op;
		pattern     <= pat;
		duration_ms <= ms;
		mute        <= mu;
		req_valid   <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		// the request was taken at this edge
		step_buzzer(op, pat, ms, mu, pred);
		status_due.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// result side: results are held back at random, except in steady stretches
	initial begin : result_stall
		int gap;
		res_stall = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = idle_cycles();
			if (gap > 0) begin
				res_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			res_stall <= 1'b0;
			do
				@(posedge clk);
			while (res_valid !== 1'b1);
			@(negedge clk);
		end
	end

	// every taken result is compared with the oldest outstanding expectation
	always @(posedge clk) begin : take_status
		buzzer_status_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (status_due.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				want = status_due.pop_front();
				check_field("buzzer_on", want.buzz, buzzer_on);
				check_field("muted_now", want.muted, muted_now);
				check_field("queued_count", want.waiting, queued_count);
				check_field("accepted", want.taken, accepted);
				check_field("playing", want.busy, playing);
			end
		end
	end

	// hard stop in case the handshake hangs
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if (cycle_no >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : stimulus
		cmd_t        op;
		logic [2:0]  pat;
		logic [15:0] ms;
		logic        mu;
		int unsigned pick;
		steady      = 1'b0;
		n_waiting   = 0;
		muted_st    = 1'b0;
		act_pat     = PAT_CLICK;
		act_len     = 16'd0;
		seg_idx     = 3'd0;
		seg_left    = 16'd0;
		busy_st     = 1'b0;
		drive_st    = 1'b0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		cmd         = CMD_TICK;
		pattern     = PAT_CLICK;
		duration_ms = 16'd0;
		mute        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < SCRIPT_LEN; i++)
			put_request(SCRIPT[i].op, SCRIPT[i].pat, SCRIPT[i].ms, SCRIPT[i].mu,
				SCRIPT[i].typed, SCRIPT[i].want);

		// random part: mostly ticks while there is something to play, so that
		// whole patterns run out; unused fields carry random noise
		for (int k = 0; k < NUM_RANDOM; k++) begin
			if (k % 64 == 0)
				steady = ($urandom_range(0, 3) == 0);
			pat  = 3'($urandom_range(0, 7));
			ms   = 16'($urandom_range(0, 16'hFFFF));
			mu   = 1'($urandom_range(0, 1));
			pick = $urandom_range(0, 99);
			if (pick < ((busy_st || n_waiting != 0) ? 75 : 25)) begin
				op = CMD_TICK;
			end else begin
				pick = $urandom_range(0, 9);
				if (pick < 2) begin
					op = CMD_MUTE;
					// stay unmuted most of the time
					mu = muted_st ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 4) == 0);
				end else if (pick < 6) begin
					op = CMD_PLAY;
				end else begin
					op = CMD_CUSTOM;
					// long beeps only where they get dropped anyway
					if (!muted_st && n_waiting < QUEUE_DEPTH) begin
						pick = $urandom_range(0, 9);
						if (pick < 6)
							ms = 16'($urandom_range(0, 8));
						else if (pick < 9)
							ms = 16'($urandom_range(0, 120));
						else
							ms = 16'($urandom_range(0, 400));
					end
				end
			end
			put_request(op, pat, ms, mu, 1'b0, '0);
		end
		req_valid <= 1'b0;

		while (status_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/bpps_pkg.sv
design/bpps_cell.sv
design/bpps_seq.sv
design/buzzer_pattern_priority_sequencer_core.sv
dv/buzzer_pattern_priority_sequencer_core_test.sv
